[design/fp32_adder_top_assert.svh]
// Assertion macros shared by the fp32 adder checker.
`ifndef FP32_ADDER_TOP_ASSERT_SVH
`define FP32_ADDER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define FP32A_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fp32 adder check failed");

// Next-cycle implication, sampled on clk, off during reset
`define FP32A_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fp32 adder check failed");

`endif

[design/fp32a_pkg.sv]
// Shared widths, constants and types of the fp32 adder.
`default_nettype none

package fp32a_pkg;

    localparam int SIG_W  = 24;   // significand with hidden bit
    localparam int ACC_W  = 26;   // sum with carry and guard bit
    localparam int LEAD_W = 5;    // position of leading one in the sum
    localparam logic [7:0] EXP_MAX = 8'hFF;

    // Control that travels with the sum into normalize and round
    typedef struct packed {
        logic       sign;
        logic [7:0] exp;
        logic       same;
        logic       sticky;
        logic       zero;
    } norm_ctrl_t;

endpackage

`default_nettype wire

[design/fp32a_round.sv]
// Normalize and round the aligned sum into a binary32 word.
`default_nettype none

module fp32a_round
(
    input  wire fp32a_pkg::norm_ctrl_t              ctrl,
    input  wire logic [fp32a_pkg::ACC_W-1:0]        acc,
    input  wire logic [fp32a_pkg::LEAD_W-1:0]       lead,
    output logic [31:0]                             word
);

    logic signed [9:0]               exp_int;
    logic [7:0]                      exp_res;
    logic [22:0]                     mant;
    logic [4:0]                      lshift;
    logic [fp32a_pkg::ACC_W-1:0]     left;
    logic [fp32a_pkg::ACC_W:0]       inc;
    logic [fp32a_pkg::ACC_W:0]       rnd;
    logic [fp32a_pkg::ACC_W:0]       shifted;
    logic                            b0;
    logic                            b1;
    logic                            b2;

    // Biased result exponent: exp + lead - 24
    always_comb
    begin
        exp_int = $signed({2'b00, ctrl.exp}) + $signed({5'b00000, lead}) - 10'sd24;
    end

    // Left shift when the leading one sits below the hidden position
    always_comb
    begin
        lshift = 5'd23 - lead;
        left   = acc << lshift;
    end

    // Round the guard bit when the leading one sits at the hidden or carry position
    always_comb
    begin
        b0  = acc[0];
        b1  = acc[1];
        b2  = acc[2];
        inc = '0;
        if (lead == 5'd25)
        begin
            inc[2] = b1 & (b0 | b2 | ctrl.sticky);
        end
        else if (ctrl.same)
        begin
            inc[1] = b0 & (b1 | ctrl.sticky);
        end
        else
        begin
            inc[1] = b0 & b1 & ~ctrl.sticky;
        end
        rnd     = {1'b0, acc} + inc;
        shifted = (lead == 5'd25) ? (rnd >> 2) : (rnd >> 1);
    end

    // Assemble the word, with zero, flush and infinity cases
    always_comb
    begin
        exp_res = exp_int[7:0];
        if (lead <= 5'd23)
        begin
            mant = left[22:0];
        end
        else if (|shifted[fp32a_pkg::ACC_W:24])
        begin
            exp_res = exp_int[7:0] + 8'd1;
            mant    = '0;
        end
        else
        begin
            mant = shifted[22:0];
        end
        if (exp_res == fp32a_pkg::EXP_MAX)
        begin
            mant = '0;
        end

        if (ctrl.zero)
        begin
            word = '0;
        end
        else if (exp_int <= 10'sd0)
        begin
            word = {ctrl.sign, 31'd0};
        end
        else
        begin
            word = {ctrl.sign, exp_res, mant};
        end
    end

endmodule

`default_nettype wire

[design/fp32_adder_top.sv]
// Four-stage binary32 adder, round to nearest even.
// Each accepted operand transaction becomes a sum transaction, and one
// enters every cycle unless a sum is held. Stages: operand swap by
// magnitude, alignment shift with add or subtract, leading-one search,
// normalize and round. The pipeline moves as one: while a sum is held
// by sum_stall, every stage holds and operand_stall is raised.
`default_nettype none

module fp32_adder_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        operand_valid,
    output logic             operand_stall,
    input  wire logic [31:0] operand_a,
    input  wire logic [31:0] operand_b,
    output logic             sum_valid,
    input  wire logic        sum_stall,
    output logic [31:0]      sum_word
);

    logic                               advance;
    logic                               v1_reg;
    logic                               v2_reg;
    logic                               v3_reg;
    logic                               v4_reg;

    // Stage 1 results
    logic                               swap;
    logic [31:0]                        big;
    logic [31:0]                        sml;
    logic                               s1_sign_reg;
    logic [7:0]                         s1_exp_reg;
    logic [7:0]                         s1_de_reg;
    logic [fp32a_pkg::SIG_W-1:0]        s1_sig_big_reg;
    logic [fp32a_pkg::SIG_W-1:0]        s1_sig_sml_reg;
    logic                               s1_same_reg;

    // Stage 2 results
    logic [4:0]                         dshift;
    logic [24:0]                        aligned;
    logic                               sticky;
    logic [fp32a_pkg::ACC_W-1:0]        acc_next;
    logic [fp32a_pkg::ACC_W-1:0]        s2_acc_reg;
    logic                               s2_sticky_reg;
    logic                               s2_sign_reg;
    logic [7:0]                         s2_exp_reg;
    logic                               s2_same_reg;

    // Stage 3 results
    logic [fp32a_pkg::LEAD_W-1:0]       lead_next;
    logic [fp32a_pkg::ACC_W-1:0]        s3_acc_reg;
    logic [fp32a_pkg::LEAD_W-1:0]       s3_lead_reg;
    fp32a_pkg::norm_ctrl_t              s3_ctrl_reg;

    logic [31:0]                        word_next;
    logic [31:0]                        sum_word_reg;

    // Whole pipeline holds while a finished sum waits
    assign advance       = !(v4_reg && sum_stall);
    assign operand_stall = !advance;
    assign sum_valid     = v4_reg;
    assign sum_word      = sum_word_reg;

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= operand_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Stage 1: order operands by magnitude
    always_comb
    begin
        swap = operand_a[30:0] < operand_b[30:0];
        big  = swap ? operand_b : operand_a;
        sml  = swap ? operand_a : operand_b;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_sign_reg    <= big[31];
            s1_exp_reg     <= big[30:23];
            s1_de_reg      <= big[30:23] - sml[30:23];
            s1_sig_big_reg <= {1'b1, big[22:0]};
            s1_sig_sml_reg <= {1'b1, sml[22:0]};
            s1_same_reg    <= big[31] == sml[31];
        end
    end

    // Stage 2: align smaller significand, then add or subtract
    always_comb
    begin
        dshift  = 5'(s1_de_reg - 8'd1);
        aligned = '0;
        sticky  = 1'b0;
        if (s1_de_reg == 8'd0)
        begin
            aligned = {s1_sig_sml_reg, 1'b0};
        end
        else if (s1_de_reg <= 8'd24)
        begin
            aligned = {1'b0, s1_sig_sml_reg} >> dshift;
            sticky  = |(s1_sig_sml_reg[22:0] & ~({23{1'b1}} << dshift));
        end
        else
        begin
            sticky = 1'b1;
        end
        if (s1_same_reg)
        begin
            acc_next = {1'b0, s1_sig_big_reg, 1'b0} + {1'b0, aligned};
        end
        else
        begin
            acc_next = {1'b0, s1_sig_big_reg, 1'b0} - {1'b0, aligned};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_acc_reg    <= acc_next;
            s2_sticky_reg <= sticky;
            s2_sign_reg   <= s1_sign_reg;
            s2_exp_reg    <= s1_exp_reg;
            s2_same_reg   <= s1_same_reg;
        end
    end

    // Stage 3: leading-one search
    always_comb
    begin
        lead_next = '0;
        for (int i = 0; i < fp32a_pkg::ACC_W; i++)
        begin
            if (s2_acc_reg[i])
            begin
                lead_next = fp32a_pkg::LEAD_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_acc_reg         <= s2_acc_reg;
            s3_lead_reg        <= lead_next;
            s3_ctrl_reg.sign   <= s2_sign_reg;
            s3_ctrl_reg.exp    <= s2_exp_reg;
            s3_ctrl_reg.same   <= s2_same_reg;
            s3_ctrl_reg.sticky <= s2_sticky_reg;
            s3_ctrl_reg.zero   <= s2_acc_reg == '0;
        end
    end

    // Stage 4: normalize and round
    fp32a_round u_round
    (
        .ctrl (s3_ctrl_reg),
        .acc  (s3_acc_reg),
        .lead (s3_lead_reg),
        .word (word_next)
    );

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sum_word_reg <= word_next;
        end
    end

endmodule

`default_nettype wire

[design/fp32a_checker.sv]
// Port-level checks of the fp32 adder, bound to the top level.
`default_nettype none

`include "fp32_adder_top_assert.svh"

module fp32a_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        operand_valid,
    input wire logic        operand_stall,
    input wire logic [31:0] operand_a,
    input wire logic [31:0] operand_b,
    input wire logic        sum_valid,
    input wire logic        sum_stall,
    input wire logic [31:0] sum_word
);

    // A held sum transaction stays offered and unchanged
    `FP32A_ASSERT_NEXT(a_sum_hold, sum_valid && sum_stall, sum_valid)
    `FP32A_ASSERT_NEXT(a_sum_stable, sum_valid && sum_stall, $stable(sum_word))

    // Operands are refused only behind a held sum
    `FP32A_ASSERT_NOW(a_stall_cause, operand_stall, sum_valid && sum_stall)

    // With no receiver stall on the way, an accepted transaction comes out as a sum
    `FP32A_ASSERT_NEXT(a_latency, (operand_valid && !operand_stall) ##1 !sum_stall [*3], sum_valid)

endmodule

bind fp32_adder_top fp32a_checker u_fp32a_checker (.*);

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the four-stage binary32 adder.
`default_nettype none

module tb;

    logic        clk;
    logic        rst_n;
    logic        operand_valid;
    logic        operand_stall;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic        sum_valid;
    logic        sum_stall;
    logic [31:0] sum_word;

    logic [31:0] sum_expect_q[$];
    int          error_count;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_stall_pct;

    localparam logic [31:0] MAG_MASK   = 32'h7FFF_FFFF;
    localparam logic [31:0] MANT_MASK  = 32'h007F_FFFF;
    localparam logic [31:0] HIDDEN_BIT = 32'h0080_0000;
    localparam logic [31:0] CARRY_LIM  = 32'h0100_0000;
    localparam logic [31:0] EXP_MASK   = 32'h0000_00FF;
    localparam int          CYCLE_LIMIT = 200000;

    fp32_adder_top DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .operand_valid (operand_valid),
        .operand_stall (operand_stall),
        .operand_a     (operand_a),
        .operand_b     (operand_b),
        .sum_valid     (sum_valid),
        .sum_stall     (sum_stall),
        .sum_word      (sum_word)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Bit-exact prediction of the rounded sum
    function automatic logic [31:0] predict_sum(logic [31:0] a, logic [31:0] b);
        logic [31:0] big, sml, aligned, wide, acc, mant, exp_res;
        logic        big_sign, same, sticky, b0, b1, b2;
        int          big_exp, small_exp, diff, lead, sh, exp_int;
        big = a;
        sml = b;
        if ((a << 1) < (b << 1))
        begin
            big = b;
            sml = a;
        end
        big_sign  = big[31];
        same      = (big[31] == sml[31]);
        big_exp   = int'((big & MAG_MASK) >> 23);
        small_exp = int'((sml & MAG_MASK) >> 23);
        sticky    = 1'b0;
        diff      = big_exp - small_exp - 1;
        if (diff < 0)
            aligned = ((sml & MANT_MASK) | HIDDEN_BIT) << 1;
        else if (diff < 24)
        begin
            aligned = ((sml & MANT_MASK) | HIDDEN_BIT) >> diff;
            sticky  = ((sml & (MANT_MASK >> (23 - diff))) != 0);
        end
        else
        begin
            aligned = 0;
            sticky  = 1'b1;
        end
        wide = ((big & MANT_MASK) | HIDDEN_BIT) << 1;
        acc  = same ? wide + aligned : wide - aligned;
        if (acc == 0)
            return 32'h0;
        lead = 25;
        while (lead > 0 && acc[lead] == 1'b0)
            lead--;
        sh      = lead - 23;
        exp_int = big_exp + sh - 1;
        if (exp_int <= 0)
            return {big_sign, 31'h0};
        exp_res = exp_int & EXP_MASK;
        if (sh <= 0)
            mant = (acc << (-sh)) & MANT_MASK;
        else
        begin
            b0 = acc[0];
            b1 = acc[1];
            b2 = acc[2];
            if (sh == 2)
                acc += 4 * (b1 & (b0 | b2 | sticky));
            else if (same)
                acc += 2 * (b0 & (b1 | sticky));
            else
                acc += 2 * (b0 & b1 & ~sticky);
            if ((acc >> sh) >= CARRY_LIM)
            begin
                exp_res = (exp_res + 1) & EXP_MASK;
                mant    = 0;
            end
            else
                mant = (acc >> sh) & MANT_MASK;
        end
        if (exp_res == EXP_MASK)
            mant = 0;
        return {big_sign, exp_res[7:0], mant[22:0]};
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_w);
        $display("MISMATCH %s: got %h expected %h", what, got, exp_w);
        error_count++;
    endtask

    // Send one operand transaction, with random idle before it;
    // valid stays high afterwards so back-to-back transactions need no gap
    task automatic send_operands(logic [31:0] a, logic [31:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            operand_valid <= 1'b0;
            @(negedge clk);
        end
        operand_valid <= 1'b1;
        operand_a     <= a;
        operand_b     <= b;
        @(posedge clk);
        while (operand_stall)
            @(posedge clk);
        sum_expect_q.push_back(predict_sum(a, b));
        @(negedge clk);
    endtask

    // Receiver stall, changed at falling edges
    always @(negedge clk)
        if (rst_n)
            sum_stall <= ($urandom_range(99) < recv_stall_pct);

    // Result checker and cycle limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
        else if (rst_n && sum_valid && !sum_stall)
        begin
            if (sum_expect_q.size() == 0)
                report_mismatch("unexpected sum", sum_word, 32'h0);
            else if (sum_word !== sum_expect_q[0])
                report_mismatch("sum_word", sum_word, sum_expect_q.pop_front());
            else
                void'(sum_expect_q.pop_front());
        end
    end

    function automatic logic [31:0] rand_float(int emin, int emax);
        return {1'($urandom), 8'($urandom_range(emax, emin)), 23'($urandom)};
    endfunction

    // Stop sending and wait until every expected sum has come
    task automatic wait_drained();
        operand_valid <= 1'b0;
        while (sum_expect_q.size() != 0)
            @(negedge clk);
    endtask

    // Extremes and special cases
    task automatic test_directed();
        send_operands(32'h3F80_0000, 32'hBF80_0000);   // exact cancellation
        send_operands(32'h0000_0000, 32'h0000_0000);
        send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_operands(32'h7F7F_FFFF, 32'h7F7F_FFFF);   // overflow to infinity
        send_operands(32'h7F80_0000, 32'h3F80_0000);   // infinity as number
        send_operands(32'h7FC0_0001, 32'hFFC0_0000);   // NaN patterns
        send_operands(32'h0080_0000, 32'h8080_0001);   // underflow
        send_operands(32'h0000_0001, 32'h0000_0002);   // subnormals
        send_operands(32'h3F80_0000, 32'h3380_0000);   // tie, guard only
        send_operands(32'h3F80_0001, 32'h3380_0000);   // tie to even up
        send_operands(32'h3F80_0000, 32'h3380_0001);   // sticky
        send_operands(32'h3F80_0000, 32'hB380_0001);   // subtract with sticky
        send_operands(32'h3F80_0001, 32'hB300_0000);
        send_operands(32'h3FFF_FFFF, 32'h3FFF_FFFF);   // carry out
        send_operands(32'h3FFF_FFFF, 32'h3400_0000);   // exact add carries into exponent
        send_operands(32'h4000_0000, 32'hBFFF_FFFF);   // deep cancellation
        send_operands(32'h4000_0000, 32'hBF80_0001);
        send_operands(32'h3F80_0000, 32'h0000_0001);   // huge exponent gap
        send_operands(32'hBF80_0000, 32'h3F00_0000);
        send_operands(32'h0000_0000, 32'hFFFF_FFFF);
        send_operands(32'hAAAA_AAAA, 32'h5555_5555);
    endtask

    // Random operands, mostly close exponents so rounding paths get exercised
    task automatic test_random(int count);
        logic [31:0] a, b;
        int          ea;
        repeat (count)
        begin
            case ($urandom_range(3))
                0:
                begin
                    a = $urandom;
                    b = $urandom;
                end
                1:
                begin
                    a  = rand_float(1, 254);
                    ea = a[30:23];
                    b  = {1'($urandom), 8'(ea), 23'($urandom)};
                end
                default:
                begin
                    a  = rand_float(30, 225);
                    ea = a[30:23];
                    b  = rand_float(ea - 26, ea);
                end
            endcase
            if ($urandom_range(1))
                send_operands(a, b);
            else
                send_operands(b, a);
        end
    endtask

    task automatic test_phase(int idle_pct, int stall_pct, int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        test_random(count);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        operand_valid  = 1'b0;
        operand_a      = '0;
        operand_b      = '0;
        sum_stall      = 1'b0;
        error_count    = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_phase(0, 0, 175);
        test_phase(48, 0, 175);
        // sender holds off until the pipeline is empty
        wait_drained();
        test_phase(0, 48, 175);
        test_phase(16, 16, 175);
        wait_drained();
        repeat (20) @(negedge clk);

        if (error_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
+incdir+design
design/fp32a_pkg.sv
design/fp32a_round.sv
design/fp32_adder_top.sv
design/fp32a_checker.sv
tb/tb.sv
